// ===== hdl/tld_pkg.sv =====
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types and constants for the terminal line discipline unit.
// ----------------------------------------------------------------------------
package tld_pkg;

  // Buffer geometry
  localparam int BUF_DEPTH  = 1024;
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int READ_BURST = 32;
  localparam int RLEN_W     = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KILL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EOF     = 3'd6;

  // Mode flag bit positions
  localparam int F_CRNL   = 0;
  localparam int F_IGNCR  = 1;
  localparam int F_INLCR  = 2;
  localparam int F_ISIG   = 3;
  localparam int F_ICANON = 4;
  localparam int F_ECHO   = 5;
  localparam int F_ECHOE  = 6;
  localparam int F_ECHOK  = 7;

  // Register reset values
  localparam logic [7:0] MODE_RST  = 8'd249;
  localparam logic [7:0] INTR_RST  = 8'd3;
  localparam logic [7:0] QUIT_RST  = 8'd28;
  localparam logic [7:0] SUSP_RST  = 8'd26;
  localparam logic [7:0] ERASE_RST = 8'd127;
  localparam logic [7:0] KILL_RST  = 8'd21;
  localparam logic [7:0] EOF_RST   = 8'd4;

  // Characters
  localparam logic [7:0] BS_BYTE    = 8'd8;
  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] NL_BYTE    = 8'd10;
  localparam logic [7:0] CARET_BYTE = 8'd94;
  localparam logic [7:0] CARET_BASE = 8'd64;

  // Operations
  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_FLUSH   = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // Result kinds
  localparam logic [2:0] K_DONE   = 3'd0;
  localparam logic [2:0] K_ECHO   = 3'd1;
  localparam logic [2:0] K_RUBOUT = 3'd2;
  localparam logic [2:0] K_SIGNAL = 3'd3;
  localparam logic [2:0] K_READ   = 3'd4;
  localparam logic [2:0] K_BLOCK  = 3'd5;
  localparam logic [2:0] K_EOF    = 3'd6;

  // Signal codes
  localparam logic [1:0] SIG_INTR = 2'd0;
  localparam logic [1:0] SIG_QUIT = 2'd1;
  localparam logic [1:0] SIG_SUSP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SIG_ECHO,
    ST_FINAL,
    ST_COMMIT_RD,
    ST_COMMIT_WR,
    ST_READ_RD,
    ST_READ_WR
  } state_t;

endpackage

// ===== hdl/tld_if.sv =====
// ----------------------------------------------------------------------------
// tld_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface tld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic [5:0] read_length;

  modport source (output valid, operation, rx_byte, read_length, input ready);
  modport sink   (input valid, operation, rx_byte, read_length, output ready);
endinterface

interface tld_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [10:0] rubout_count;
  logic [1:0]  signal_kind;
  logic        wake_readers;
  logic        last;

  modport source (output valid, kind, data_byte, rubout_count, signal_kind,
                  wake_readers, last, input ready);
  modport sink   (input valid, kind, data_byte, rubout_count, signal_kind,
                  wake_readers, last, output ready);
endinterface

// ===== hdl/tld_ram.sv =====
// ----------------------------------------------------------------------------
// tld_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/terminal_line_discipline_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_line_discipline_unit
// Canonical/raw keyboard line discipline: edit line and ready ring in RAM.
// ----------------------------------------------------------------------------
//  channel  dir  words
//  in_ch    in   operation, rx_byte, read_length
//  out_ch   out  kind, data_byte, rubout_count, signal_kind, wake_readers, last
//  cfg_*    in   write enable, register index, data
//
//  One request at a time: a plain byte goes through ST_DECODE and then ST_FINAL.
//  A line commit walks the edit RAM: ST_COMMIT_RD reads a byte, ST_COMMIT_WR writes it.
//  A read burst pops each byte from the ready ring via ST_READ_RD and ST_READ_WR.
//  Output stalls hold the sequencer; the output register frees in_ch early.
//  Sync reset clears state, counters, config and out_valid; RAM contents are unused.
// ----------------------------------------------------------------------------
module terminal_line_discipline_unit (
  input  logic                              clk,
  input  logic                              rst,
  tld_in_if.sink                            in_ch,
  tld_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [tld_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import tld_pkg::*;

  // Configuration registers
  logic [7:0] mode, intr_ch, quit_ch, susp_ch, erase_ch, kill_ch, eof_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_RST;
      intr_ch  <= INTR_RST;
      quit_ch  <= QUIT_RST;
      susp_ch  <= SUSP_RST;
      erase_ch <= ERASE_RST;
      kill_ch  <= KILL_RST;
      eof_ch   <= EOF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode     <= cfg_data;
        REG_INTR:  intr_ch  <= cfg_data;
        REG_QUIT:  quit_ch  <= cfg_data;
        REG_SUSP:  susp_ch  <= cfg_data;
        REG_ERASE: erase_ch <= cfg_data;
        REG_KILL:  kill_ch  <= cfg_data;
        REG_EOF:   eof_ch   <= cfg_data;
        default: ;
      endcase
    end
  end

  // State
  state_t            state, state_next;
  logic [CNT_W-1:0]  line_len, line_len_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              eof_pend, eof_pend_next;
  logic [CNT_W-1:0]  cm_idx, cm_idx_next;
  logic [RLEN_W-1:0] rd_left, rd_left_next;
  logic [1:0]        sig_step, sig_step_next;
  logic [2:0]        fin_kind, fin_kind_next;
  logic [7:0]        fin_data, fin_data_next;
  logic [CNT_W-1:0]  fin_rub, fin_rub_next;
  logic [1:0]        fin_sig, fin_sig_next;
  logic              fin_wake, fin_wake_next;

  // Output register
  logic              out_valid, out_valid_next;
  logic [2:0]        out_kind, out_kind_next;
  logic [7:0]        out_data, out_data_next;
  logic [CNT_W-1:0]  out_rub, out_rub_next;
  logic [1:0]        out_sig, out_sig_next;
  logic              out_wake, out_wake_next;
  logic              out_last, out_last_next;

  // Latched request word
  logic [1:0]        op_q;
  logic [7:0]        byte_q;
  logic [RLEN_W-1:0] rlen_q;

  // RAM ports
  logic              edit_we, ring_we;
  logic [ADDR_W-1:0] edit_waddr, edit_raddr, ring_waddr, ring_raddr;
  logic [7:0]        edit_wdata, edit_rdata, ring_wdata, ring_rdata;

  tld_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_edit_ram (
    .clk(clk), .we(edit_we), .waddr(edit_waddr), .wdata(edit_wdata),
    .raddr(edit_raddr), .rdata(edit_rdata)
  );

  tld_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ring_ram (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  logic in_fire, out_free, emit_last_fire;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // Input translation and character classes
  logic [7:0] c;
  logic       ignore_cr, sig_hit, is_erase, edit_full, ring_full, rd_stop;
  logic [1:0] sig_code;
  logic [RLEN_W-1:0] rlen_sat;

  always_comb begin
    c         = byte_q;
    ignore_cr = 1'b0;
    if (mode[F_CRNL]) begin
      if (byte_q == CR_BYTE) c = NL_BYTE;
    end else if (mode[F_IGNCR] && byte_q == CR_BYTE) begin
      ignore_cr = 1'b1;
    end
    if (mode[F_INLCR] && c == NL_BYTE) c = CR_BYTE;

    sig_hit  = 1'b1;
    sig_code = SIG_INTR;
    if (c == intr_ch)      sig_code = SIG_INTR;
    else if (c == quit_ch) sig_code = SIG_QUIT;
    else if (c == susp_ch) sig_code = SIG_SUSP;
    else                   sig_hit  = 1'b0;
  end

  assign is_erase  = (c == erase_ch) || (c == BS_BYTE);
  assign edit_full = (line_len == CNT_W'(BUF_DEPTH));
  assign ring_full = (count == CNT_W'(BUF_DEPTH));
  assign rlen_sat  = (rlen_q > RLEN_W'(READ_BURST)) ? RLEN_W'(READ_BURST) : rlen_q;
  assign rd_stop   = (rd_left == RLEN_W'(1)) || (count == CNT_W'(1)) ||
                     (mode[F_ICANON] && ring_rdata == NL_BYTE);

  // Sequencer
  always_comb begin
    state_next    = state;
    line_len_next = line_len;
    head_next     = head;
    count_next    = count;
    eof_pend_next = eof_pend;
    cm_idx_next   = cm_idx;
    rd_left_next  = rd_left;
    sig_step_next = sig_step;
    fin_kind_next = fin_kind;
    fin_data_next = fin_data;
    fin_rub_next  = fin_rub;
    fin_sig_next  = fin_sig;
    fin_wake_next = fin_wake;

    out_valid_next = out_valid && !out_ch.ready;
    out_kind_next  = out_kind;
    out_data_next  = out_data;
    out_rub_next   = out_rub;
    out_sig_next   = out_sig;
    out_wake_next  = out_wake;
    out_last_next  = out_last;
    emit_last_fire = 1'b0;

    edit_we    = 1'b0;
    edit_waddr = line_len[ADDR_W-1:0];
    edit_wdata = c;
    edit_raddr = cm_idx[ADDR_W-1:0];
    ring_we    = 1'b0;
    ring_waddr = head + count[ADDR_W-1:0];
    ring_wdata = c;
    ring_raddr = head;

    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_DECODE;
      end

      ST_DECODE: begin
        fin_kind_next = K_DONE;
        fin_data_next = 8'd0;
        fin_rub_next  = '0;
        fin_sig_next  = SIG_INTR;
        fin_wake_next = 1'b0;
        state_next    = ST_FINAL;
        case (op_q)
          OP_RX: begin
            if (ignore_cr) begin
              // dropped carriage return
            end else if (mode[F_ISIG] && sig_hit) begin
              line_len_next = '0;
              fin_kind_next = K_SIGNAL;
              fin_sig_next  = sig_code;
              fin_wake_next = 1'b1;
              if (mode[F_ECHO]) begin
                sig_step_next = 2'd0;
                state_next    = ST_SIG_ECHO;
              end
            end else if (!mode[F_ICANON]) begin
              // raw: straight to the ready ring
              fin_wake_next = 1'b1;
              if (!ring_full) begin
                ring_we    = 1'b1;
                count_next = count + CNT_W'(1);
              end
              if (mode[F_ECHO]) begin
                fin_kind_next = K_ECHO;
                fin_data_next = c;
              end
            end else if (is_erase) begin
              if (line_len != '0) begin
                line_len_next = line_len - CNT_W'(1);
                if (mode[F_ECHOE]) begin
                  fin_kind_next = K_RUBOUT;
                  fin_rub_next  = CNT_W'(1);
                end
              end
            end else if (c == kill_ch) begin
              if (mode[F_ECHOK] && line_len != '0) begin
                fin_kind_next = K_RUBOUT;
                fin_rub_next  = line_len;
              end
              line_len_next = '0;
            end else if (c == eof_ch) begin
              fin_wake_next = 1'b1;
              if (line_len == '0) begin
                eof_pend_next = 1'b1;
              end else begin
                cm_idx_next = '0;
                state_next  = ST_COMMIT_RD;
              end
            end else if (c == NL_BYTE) begin
              fin_wake_next = 1'b1;
              if (!edit_full) begin
                edit_we       = 1'b1;
                line_len_next = line_len + CNT_W'(1);
              end
              if (mode[F_ECHO]) begin
                fin_kind_next = K_ECHO;
                fin_data_next = NL_BYTE;
              end
              cm_idx_next = '0;
              state_next  = ST_COMMIT_RD;
            end else if (!edit_full) begin
              edit_we       = 1'b1;
              line_len_next = line_len + CNT_W'(1);
              if (mode[F_ECHO]) begin
                fin_kind_next = K_ECHO;
                fin_data_next = c;
              end
            end
          end
          OP_READ: begin
            if (rlen_q == '0) begin
              // empty request
            end else if (count == '0) begin
              if (eof_pend) begin
                eof_pend_next = 1'b0;
                fin_kind_next = K_EOF;
              end else begin
                fin_kind_next = K_BLOCK;
              end
            end else begin
              rd_left_next = rlen_sat;
              state_next   = ST_READ_RD;
            end
          end
          OP_FLUSH: begin
            line_len_next = '0;
            count_next    = '0;
            head_next     = '0;
          end
          default: ;
        endcase
      end

      // caret notation: '^', byte plus 64, newline
      ST_SIG_ECHO: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = K_ECHO;
          out_rub_next   = '0;
          out_sig_next   = SIG_INTR;
          out_wake_next  = 1'b0;
          out_last_next  = 1'b0;
          case (sig_step)
            2'd0:    out_data_next = CARET_BYTE;
            2'd1:    out_data_next = c + CARET_BASE;
            default: out_data_next = NL_BYTE;
          endcase
          sig_step_next = sig_step + 2'd1;
          if (sig_step == 2'd2) state_next = ST_FINAL;
        end
      end

      ST_FINAL: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = fin_kind;
          out_data_next  = fin_data;
          out_rub_next   = fin_rub;
          out_sig_next   = fin_sig;
          out_wake_next  = fin_wake;
          out_last_next  = 1'b1;
          emit_last_fire = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      // copy edit line into the ready ring
      ST_COMMIT_RD: begin
        if (cm_idx == line_len) begin
          line_len_next = '0;
          state_next    = ST_FINAL;
        end else begin
          state_next = ST_COMMIT_WR;
        end
      end

      ST_COMMIT_WR: begin
        ring_wdata = edit_rdata;
        if (!ring_full) begin
          ring_we    = 1'b1;
          count_next = count + CNT_W'(1);
        end
        cm_idx_next = cm_idx + CNT_W'(1);
        state_next  = ST_COMMIT_RD;
      end

      ST_READ_RD: begin
        state_next = ST_READ_WR;
      end

      ST_READ_WR: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = K_READ;
          out_data_next  = ring_rdata;
          out_rub_next   = '0;
          out_sig_next   = SIG_INTR;
          out_wake_next  = 1'b0;
          out_last_next  = rd_stop;
          emit_last_fire = rd_stop;
          head_next      = head + ADDR_W'(1);
          count_next     = count - CNT_W'(1);
          rd_left_next   = rd_left - RLEN_W'(1);
          state_next     = rd_stop ? ST_IDLE : ST_READ_RD;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_len  <= '0;
      head      <= '0;
      count     <= '0;
      eof_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      line_len  <= line_len_next;
      head      <= head_next;
      count     <= count_next;
      eof_pend  <= eof_pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cm_idx   <= cm_idx_next;
    rd_left  <= rd_left_next;
    sig_step <= sig_step_next;
    fin_kind <= fin_kind_next;
    fin_data <= fin_data_next;
    fin_rub  <= fin_rub_next;
    fin_sig  <= fin_sig_next;
    fin_wake <= fin_wake_next;
    out_kind <= out_kind_next;
    out_data <= out_data_next;
    out_rub  <= out_rub_next;
    out_sig  <= out_sig_next;
    out_wake <= out_wake_next;
    out_last <= out_last_next;
    if (in_fire) begin
      op_q   <= in_ch.operation;
      byte_q <= in_ch.rx_byte;
      rlen_q <= in_ch.read_length;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_kind;
  assign out_ch.data_byte    = out_data;
  assign out_ch.rubout_count = out_rub;
  assign out_ch.signal_kind  = out_sig;
  assign out_ch.wake_readers = out_wake;
  assign out_ch.last         = out_last;

`ifndef SYNTHESIS
  // ring fill never exceeds the buffer
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BUF_DEPTH)) else $error("ready ring overfilled");

  // edit line never exceeds the buffer
  a_edit_bound: assert property (@(posedge clk) disable iff (rst)
    line_len <= CNT_W'(BUF_DEPTH)) else $error("edit line overfilled");

  // closing word of a request returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit_last_fire |=> state == ST_IDLE) else $error("sequencer busy after last word");

  // wake flag only on the closing word
  a_wake_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_wake |-> out_last) else $error("wake without last");

  // a read burst only runs with data in the ring
  a_read_data: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ_WR |-> count != '0) else $error("read from empty ring");
`endif

endmodule

// ===== tb/tb_terminal_line_discipline_unit.sv =====
// ----------------------------------------------------------------------------
// tb_terminal_line_discipline_unit
// Self-checking bench for the terminal line discipline unit. A directed table
// walks reset defaults, editing, signals, end of file, reads and flush. It is
// followed by random phases under several mode and character settings. Every
// accepted request is run through a local model of the discipline, and each
// result word is compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module tb_terminal_line_discipline_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tld_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [10:0] rub;
    logic [1:0]  sig;
    logic        wake;
    logic        last;
  } word_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] b;
    logic [5:0] len;
    bit         typed;
    logic [2:0] kind;
    logic [7:0] data;
    logic       wake;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tld_in_if  in_ch ();
  tld_out_if out_ch ();

  terminal_line_discipline_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state
  logic [7:0] cfg_shadow [7];
  logic [7:0] edit_buf [BUF_DEPTH];
  int         line_cnt;
  logic [7:0] ready_buf [BUF_DEPTH];
  int         ring_head, ready_cnt;
  bit         eof_flag;

  word_t expected_words [$];
  word_t reply [$];
  int    fails = 0;
  bit    quiet = 1'b0;
  bit    hold_req = 1'b0;

  function automatic void add_word(logic [2:0] k, logic [7:0] d, logic [10:0] r,
                                   logic [1:0] s);
    word_t w;
    w = '{kind: k, data: d, rub: r, sig: s, wake: 1'b0, last: 1'b0};
    if (reply.size() < READ_BURST + 1) reply.push_back(w);
  endfunction

  function automatic void ring_push(logic [7:0] b);
    if (ready_cnt < BUF_DEPTH) begin
      ready_buf[(ring_head + ready_cnt) % BUF_DEPTH] = b;
      ready_cnt++;
    end
  endfunction

  function automatic void commit_edit();
    for (int i = 0; i < line_cnt; i++) ring_push(edit_buf[i]);
    line_cnt = 0;
  endfunction

  // Received byte: returns whether readers get woken
  function automatic bit rx_predict(logic [7:0] b);
    logic [7:0] m;
    logic [7:0] c;
    int sg;
    m = cfg_shadow[REG_MODE];
    c = b;
    sg = -1;
    if (m[F_CRNL]) begin
      if (c == CR_BYTE) c = NL_BYTE;
    end else if (m[F_IGNCR] && c == CR_BYTE) begin
      return 1'b0;
    end
    if (m[F_INLCR] && c == NL_BYTE) c = CR_BYTE;
    if (m[F_ISIG]) begin
      if (c == cfg_shadow[REG_INTR]) sg = SIG_INTR;
      else if (c == cfg_shadow[REG_QUIT]) sg = SIG_QUIT;
      else if (c == cfg_shadow[REG_SUSP]) sg = SIG_SUSP;
      if (sg >= 0) begin
        line_cnt = 0;
        if (m[F_ECHO]) begin
          add_word(K_ECHO, CARET_BYTE, 0, 0);
          add_word(K_ECHO, CARET_BASE + c, 0, 0);
          add_word(K_ECHO, NL_BYTE, 0, 0);
        end
        add_word(K_SIGNAL, 0, 0, sg[1:0]);
        return 1'b1;
      end
    end
    if (!m[F_ICANON]) begin
      ring_push(c);
      if (m[F_ECHO]) add_word(K_ECHO, c, 0, 0);
      return 1'b1;
    end
    if (c == cfg_shadow[REG_ERASE] || c == BS_BYTE) begin
      if (line_cnt > 0) begin
        line_cnt--;
        if (m[F_ECHOE]) add_word(K_RUBOUT, 0, 1, 0);
      end
      return 1'b0;
    end
    if (c == cfg_shadow[REG_KILL]) begin
      if (m[F_ECHOK] && line_cnt > 0) add_word(K_RUBOUT, 0, line_cnt[10:0], 0);
      line_cnt = 0;
      return 1'b0;
    end
    if (c == cfg_shadow[REG_EOF]) begin
      if (line_cnt == 0) eof_flag = 1'b1;
      else commit_edit();
      return 1'b1;
    end
    if (c == NL_BYTE) begin
      if (line_cnt < BUF_DEPTH) edit_buf[line_cnt++] = c;
      if (m[F_ECHO]) add_word(K_ECHO, NL_BYTE, 0, 0);
      commit_edit();
      return 1'b1;
    end
    if (line_cnt < BUF_DEPTH) begin
      edit_buf[line_cnt++] = c;
      if (m[F_ECHO]) add_word(K_ECHO, c, 0, 0);
    end
    return 1'b0;
  endfunction

  // Full request: leaves the result words of one request in reply
  function automatic void discipline_predict(logic [1:0] op, logic [7:0] b,
                                             logic [5:0] len);
    bit wake;
    int n;
    logic [7:0] rb;
    wake = 1'b0;
    n = (len > READ_BURST) ? READ_BURST : len;
    reply.delete();
    if (op == OP_RX) begin
      wake = rx_predict(b);
    end else if (op == OP_READ && n > 0) begin
      if (ready_cnt == 0) begin
        if (eof_flag) begin
          eof_flag = 1'b0;
          add_word(K_EOF, 0, 0, 0);
        end else begin
          add_word(K_BLOCK, 0, 0, 0);
        end
      end else begin
        for (int i = 0; i < n && ready_cnt > 0; i++) begin
          rb = ready_buf[ring_head];
          ring_head = (ring_head + 1) % BUF_DEPTH;
          ready_cnt--;
          add_word(K_READ, rb, 0, 0);
          if (cfg_shadow[REG_MODE][F_ICANON] && rb == NL_BYTE) break;
        end
      end
    end else if (op == OP_FLUSH) begin
      line_cnt = 0;
      ready_cnt = 0;
      ring_head = 0;
    end
    if (reply.size() == 0) add_word(K_DONE, 0, 0, 0);
    reply[reply.size()-1].wake = wake;
    reply[reply.size()-1].last = 1'b1;
  endfunction

  // Offer one request word, wait for it to be taken, then predict it
  task automatic send_request(row_t r);
    word_t w;
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= r.op;
    in_ch.rx_byte     <= r.b;
    in_ch.read_length <= r.len;
    do @(posedge clk); while (!in_ch.ready);
    discipline_predict(r.op, r.b, r.len);
    if (r.typed) begin
      w = '{kind: r.kind, data: r.data, rub: '0, sig: '0, wake: r.wake, last: 1'b1};
      expected_words.push_back(w);
    end else begin
      foreach (reply[i]) expected_words.push_back(reply[i]);
    end
  endtask

  // Write all registers while the unit is idle
  task automatic write_config(logic [7:0] vals [7]);
    in_ch.valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      cfg_shadow[i] = vals[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: check words and drive ready, with one long hold-off
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    word_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{kind: out_ch.kind, data: out_ch.data_byte, rub: out_ch.rubout_count,
              sig: out_ch.signal_kind, wake: out_ch.wake_readers, last: out_ch.last};
      if (expected_words.size() == 0) begin
        $error("unexpected result word kind=%0d", got.kind);
        fails++;
      end else begin
        want = expected_words.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind); fails++;
        end
        if (got.data !== want.data) begin
          $error("data_byte: expected %0d, got %0d", want.data, got.data); fails++;
        end
        if (got.rub !== want.rub) begin
          $error("rubout_count: expected %0d, got %0d", want.rub, got.rub); fails++;
        end
        if (got.sig !== want.sig) begin
          $error("signal_kind: expected %0d, got %0d", want.sig, got.sig); fails++;
        end
        if (got.wake !== want.wake) begin
          $error("wake_readers: expected %0d, got %0d", want.wake, got.wake); fails++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last); fails++;
        end
      end
    end
    if (hold_req && !hold_done) begin
      hold_cnt  = 400;
      hold_done = 1'b1;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 28);
    end
  end

  // Directed table: typed rows have an obvious single result word
  row_t plan [23] = '{
    '{OP_READ, 8'd0,   6'd0,  1, K_DONE,  8'd0, 1'b0},
    '{OP_READ, 8'd0,   6'd5,  1, K_BLOCK, 8'd0, 1'b0},
    '{OP_RX,   8'd97,  6'd0,  1, K_ECHO,  8'd97, 1'b0},
    '{OP_RX,   8'd127, 6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd8,   6'd0,  1, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd98,  6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd99,  6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd21,  6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd4,   6'd0,  1, K_DONE,  8'd0, 1'b1},
    '{OP_READ, 8'd0,   6'd63, 1, K_EOF,   8'd0, 1'b0},
    '{OP_RX,   8'd120, 6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd13,  6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_READ, 8'd0,   6'd63, 0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd3,   6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd28,  6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd26,  6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd255, 6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd0,   6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_RX,   8'd4,   6'd0,  0, K_DONE,  8'd0, 1'b0},
    '{OP_READ, 8'd0,   6'd1,  0, K_DONE,  8'd0, 1'b0},
    '{OP_READ, 8'd0,   6'd32, 0, K_DONE,  8'd0, 1'b0},
    '{OP_FLUSH, 8'd0,  6'd0,  1, K_DONE,  8'd0, 1'b0},
    '{OP_IGNORED, 8'd255, 6'd0, 1, K_DONE, 8'd0, 1'b0}
  };

  // Main sequence
  initial begin
    logic [7:0] vals [7];
    row_t r;
    int sel;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.rx_byte = '0;
    in_ch.read_length = '0;
    out_ch.ready = 1'b0;
    cfg_shadow = '{MODE_RST, INTR_RST, QUIT_RST, SUSP_RST, ERASE_RST, KILL_RST, EOF_RST};
    line_cnt = 0; ring_head = 0; ready_cnt = 0; eof_flag = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_request(plan[i]);

    for (int ph = 0; ph < 6; ph++) begin
      vals = '{MODE_RST, INTR_RST, QUIT_RST, SUSP_RST, ERASE_RST, KILL_RST, EOF_RST};
      case (ph)
        0: vals[REG_MODE] = 8'd0;
        1: begin
          vals[REG_MODE] = 8'd255;
          for (int k = 1; k < 7; k++) vals[k] = 8'($urandom_range(0, 255));
        end
        2: begin
          vals[REG_MODE] = 8'($urandom_range(0, 255)) | (8'd1 << F_ICANON);
          vals[REG_INTR] = 8'd0;   vals[REG_QUIT] = 8'd255;
          vals[REG_ERASE] = 8'd0;  vals[REG_EOF] = 8'd255;
        end
        3: vals[REG_MODE] = (8'd1 << F_IGNCR) | (8'd1 << F_INLCR) |
                            (8'd1 << F_ICANON) | (8'd1 << F_ECHO);
        4: ;
        default: vals[REG_MODE] = 8'($urandom_range(0, 255));
      endcase
      write_config(vals);
      quiet    = (ph == 4);
      hold_req = (ph == 3);
      for (int n = 0; n < 48; n++) begin
        r = '{OP_RX, 8'd0, 6'd0, 0, K_DONE, 8'd0, 1'b0};
        sel = $urandom_range(0, 99);
        if (sel < 58) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: r.b = 8'd97 + 8'($urandom_range(0, 25));
            4: r.b = 8'($urandom_range(0, 255));
            5: r.b = NL_BYTE;
            6: r.b = CR_BYTE;
            7: r.b = $urandom_range(0, 1) ? BS_BYTE : cfg_shadow[REG_ERASE];
            8: r.b = cfg_shadow[$urandom_range(0, 1) ? REG_KILL : REG_EOF];
            default: r.b = cfg_shadow[$urandom_range(1, 3)];
          endcase
        end else if (sel < 92) begin
          r.op  = OP_READ;
          r.len = 6'($urandom_range(0, 63));
        end else if (sel < 96) begin
          r.op = OP_FLUSH;
        end else begin
          r.op = OP_IGNORED;
          r.b  = 8'($urandom_range(0, 255));
        end
        send_request(r);
      end
    end
    in_ch.valid <= 1'b0;
    quiet = 1'b0;
    wait (expected_words.size() == 0);
    repeat (50) @(posedge clk);
    if (fails == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
